// ===== rtl/pfse_pkg.sv =====
package pfse_pkg;

  localparam int unsigned NumRows  = 5;
  localparam int unsigned RowW     = 25;
  localparam int unsigned CodeW    = 5;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned AsciiW   = 7;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [CodeW-1:0] CodeX = 5'd23;
  localparam logic [CodeW-1:0] CodeI = 5'd8;
  localparam logic [CodeW-1:0] CodeJ = 5'd9;

  localparam logic [ByteW-1:0] AsciiUpA = 8'h41;
  localparam logic [ByteW-1:0] AsciiUpZ = 8'h5A;
  localparam logic [ByteW-1:0] AsciiLoA = 8'h61;
  localparam logic [ByteW-1:0] AsciiLoZ = 8'h7A;
  localparam logic [AsciiW-1:0] AsciiBase = 7'h41;

  localparam logic [IdxW-1:0] RegKeyRowLast = 3'd4;

  typedef logic [NumRows-1:0][RowW-1:0] key_sq_t;

  localparam key_sq_t KeyReset = {25'd2149955, 25'd6848868, 25'd25942713,
                                  25'd17283508, 25'd10755244};

  typedef struct packed {
    logic [CodeW-1:0] a;
    logic [CodeW-1:0] b;
    logic             last;
    logic             ending;
  } pair_t;

  function automatic logic [2:0] wrap_inc(input logic [2:0] x);
    logic [2:0] r;
    r = (x == 3'd4) ? 3'd0 : 3'(x + 3'd1);
    return r;
  endfunction

  function automatic logic [CodeW-1:0] cell_at(input key_sq_t sq, input logic [2:0] r,
                                               input logic [2:0] c);
    logic [RowW-1:0]  row;
    logic [CodeW-1:0] v;
    row = sq[r];
    case (c)
      3'd0:    v = row[4:0];
      3'd1:    v = row[9:5];
      3'd2:    v = row[14:10];
      3'd3:    v = row[19:15];
      default: v = row[24:20];
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/pfse_front.sv =====
module pfse_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 message_end_i,
  output logic                 full_o,
  output logic                 q_wr_o,
  output pfse_pkg::pair_t      q_wdata_o,
  input  logic                 q_full_i
);
  import pfse_pkg::*;

  logic [CodeW-1:0] prev_q, prev_d, half_q, half_d;
  logic             prev_v_q, prev_v_d, half_v_q, half_v_d;
  pair_t            slot0_q, slot0_d, slot1_q, slot1_d;
  logic             s0_v_q, s0_v_d, s1_v_q, s1_v_d;

  logic             is_letter, accept, drain;
  logic [CodeW-1:0] code;
  logic [CodeW-1:0] cand [3];
  logic             cand_v [3];
  logic             hv;
  logic [CodeW-1:0] hl;
  logic [1:0]       np;
  pair_t            pr [2];

  assign drain  = s0_v_q && !q_full_i;
  assign full_o = s1_v_q || (s0_v_q && q_full_i);
  assign accept = push_i && !full_o;
  assign q_wr_o    = drain;
  assign q_wdata_o = slot0_q;

  always_comb begin
    is_letter = 1'b0;
    code      = '0;
    if (text_byte_i >= AsciiUpA && text_byte_i <= AsciiUpZ) begin
      is_letter = 1'b1;
      code      = CodeW'(text_byte_i - AsciiUpA);
    end else if (text_byte_i >= AsciiLoA && text_byte_i <= AsciiLoZ) begin
      is_letter = 1'b1;
      code      = CodeW'(text_byte_i - AsciiLoA);
    end
    if (code == CodeJ) code = CodeI;

    cand[0]   = CodeX;
    cand_v[0] = is_letter && prev_v_q && (prev_q == code);
    cand[1]   = code;
    cand_v[1] = is_letter;
    cand[2]   = CodeX;
    cand_v[2] = 1'b0;

    hv = half_v_q;
    hl = half_q;
    np = '0;
    pr[0] = '0;
    pr[1] = '0;
    for (int k = 0; k < 3; k++) begin
      if (k == 2) cand_v[2] = message_end_i && hv;
      if (cand_v[k]) begin
        if (!hv) begin
          hl = cand[k];
          hv = 1'b1;
        end else begin
          pr[np[0]].a = hl;
          pr[np[0]].b = cand[k];
          np = 2'(np + 2'd1);
          hv = 1'b0;
        end
      end
    end
    pr[0].last   = (np == 2'd1);
    pr[1].last   = 1'b1;
    pr[0].ending = message_end_i;
    pr[1].ending = message_end_i;
  end

  always_comb begin
    prev_d   = prev_q;
    prev_v_d = prev_v_q;
    half_d   = half_q;
    half_v_d = half_v_q;
    slot0_d  = slot0_q;
    slot1_d  = slot1_q;
    s0_v_d   = s0_v_q;
    s1_v_d   = s1_v_q;
    if (drain) begin
      slot0_d = slot1_q;
      s0_v_d  = s1_v_q;
      s1_v_d  = 1'b0;
    end
    if (accept) begin
      slot0_d = pr[0];
      slot1_d = pr[1];
      s0_v_d  = (np != 2'd0);
      s1_v_d  = (np == 2'd2);
      if (message_end_i) begin
        prev_d   = '0;
        prev_v_d = 1'b0;
        half_d   = '0;
        half_v_d = 1'b0;
      end else begin
        if (is_letter) begin
          prev_d   = code;
          prev_v_d = 1'b1;
        end
        half_d   = hv ? hl : '0;
        half_v_d = hv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      prev_v_q <= 1'b0;
      half_q   <= '0;
      half_v_q <= 1'b0;
      s0_v_q   <= 1'b0;
      s1_v_q   <= 1'b0;
    end else begin
      prev_q   <= prev_d;
      prev_v_q <= prev_v_d;
      half_q   <= half_d;
      half_v_q <= half_v_d;
      s0_v_q   <= s0_v_d;
      s1_v_q   <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

// ===== rtl/pfse_fifo.sv =====
module pfse_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  pfse_pkg::pair_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output pfse_pkg::pair_t rdata_o,
  output logic            empty_o
);
  import pfse_pkg::*;

  pair_t            mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= QPtrW'(wp_q + 1'b1);
      if (do_rd) rp_q <= QPtrW'(rp_q + 1'b1);
      if (do_wr && !do_rd) cnt_q <= (QPtrW+1)'(cnt_q + 1'b1);
      else if (do_rd && !do_wr) cnt_q <= (QPtrW+1)'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

endmodule

// ===== rtl/pfse_back.sv =====
module pfse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfse_pkg::key_sq_t key_i,
  input  pfse_pkg::pair_t   q_rdata_i,
  input  logic              q_empty_i,
  output logic              q_rd_o,
  output logic              empty,
  input  logic              pop,
  output logic [6:0]        cipher_letter_o,
  output logic              last_of_run_o,
  output logic              end_of_text_o
);
  import pfse_pkg::*;

  logic             bv_q, bv_d, idx_q, idx_d;
  logic [CodeW-1:0] l0_q, l0_d, l1_q, l1_d;
  logic             last_q, last_d, end_q, end_d;
  logic             out_v_q, out_v_d;
  logic [CodeW-1:0] out_code_q, out_code_d;
  logic             out_last_q, out_last_d, out_end_q, out_end_d;
  logic             out_load, back_free;
  logic [2:0]       r1, c1, r2, c2;
  logic [CodeW-1:0] e0, e1;

  function automatic logic [5:0] locate(input key_sq_t sq, input logic [CodeW-1:0] code);
    logic [5:0] rc;
    rc = '0;
    for (int i = NumRows - 1; i >= 0; i--) begin
      for (int k = NumRows - 1; k >= 0; k--) begin
        if (cell_at(sq, 3'(i), 3'(k)) == code) rc = {3'(i), 3'(k)};
      end
    end
    return rc;
  endfunction

  always_comb begin
    {r1, c1} = locate(key_i, q_rdata_i.a);
    {r2, c2} = locate(key_i, q_rdata_i.b);
    if (r1 == r2) begin
      e0 = cell_at(key_i, r1, wrap_inc(c1));
      e1 = cell_at(key_i, r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      e0 = cell_at(key_i, wrap_inc(r1), c1);
      e1 = cell_at(key_i, wrap_inc(r2), c2);
    end else begin
      e0 = cell_at(key_i, r1, c2);
      e1 = cell_at(key_i, r2, c1);
    end
  end

  assign out_load  = bv_q && (!out_v_q || pop);
  assign back_free = !bv_q || (idx_q && out_load);
  assign q_rd_o    = back_free && !q_empty_i;

  always_comb begin
    bv_d       = bv_q;
    idx_d      = idx_q;
    l0_d       = l0_q;
    l1_d       = l1_q;
    last_d     = last_q;
    end_d      = end_q;
    out_v_d    = out_v_q;
    out_code_d = out_code_q;
    out_last_d = out_last_q;
    out_end_d  = out_end_q;
    if (out_load) begin
      out_v_d    = 1'b1;
      out_code_d = idx_q ? l1_q : l0_q;
      out_last_d = idx_q && last_q;
      out_end_d  = idx_q && last_q && end_q;
    end else if (pop) begin
      out_v_d = 1'b0;
    end
    if (back_free) begin
      bv_d   = q_rd_o;
      idx_d  = 1'b0;
      l0_d   = e0;
      l1_d   = e1;
      last_d = q_rdata_i.last;
      end_d  = q_rdata_i.ending;
    end else if (out_load) begin
      idx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q    <= 1'b0;
      idx_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      bv_q    <= bv_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l0_q       <= l0_d;
    l1_q       <= l1_d;
    last_q     <= last_d;
    end_q      <= end_d;
    out_code_q <= out_code_d;
    out_last_q <= out_last_d;
    out_end_q  <= out_end_d;
  end

  assign empty           = !out_v_q;
  assign cipher_letter_o = AsciiW'(AsciiBase + AsciiW'(out_code_q));
  assign last_of_run_o   = out_last_q;
  assign end_of_text_o   = out_end_q;

endmodule

// ===== rtl/playfair_stream_encryptor_core.sv =====
// channel  handshake        payload
// input    push / full      text_byte_i[7:0], message_end_i
// result   empty / pop      cipher_letter_o[6:0], last_of_run_o, end_of_text_o
// config   cfg_we_i         cfg_idx_i[2:0], cfg_wdata_i[24:0]
//
// One item per cycle in while the queue has room; an item that forms two pairs
// blocks input for the next cycle. Letters leave at one per cycle while pop is
// held; an item yields 0 to 4 letters, paced by the single letter output
// register, after the front pair slot, pair queue and back pair register.
// Reset clears all control state and loads the default key square.
// A 4-deep pair queue separates front and back; each side stalls on its own.
module playfair_stream_encryptor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        message_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  cipher_letter_o,
  output logic        last_of_run_o,
  output logic        end_of_text_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [24:0] cfg_wdata_i
);
  import pfse_pkg::*;

  key_sq_t key_q;
  logic    q_wr, q_full, q_rd, q_empty;
  pair_t   q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KeyReset;
    end else if (cfg_we_i && cfg_idx_i <= RegKeyRowLast) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  pfse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .text_byte_i   (text_byte_i),
    .message_end_i (message_end_i),
    .full_o        (full),
    .q_wr_o        (q_wr),
    .q_wdata_o     (q_wdata),
    .q_full_i      (q_full)
  );

  pfse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  pfse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .key_i           (key_q),
    .q_rdata_i       (q_rdata),
    .q_empty_i       (q_empty),
    .q_rd_o          (q_rd),
    .empty           (empty),
    .pop             (pop),
    .cipher_letter_o (cipher_letter_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_text_o   (end_of_text_o)
  );

endmodule
